@@ sv/hbridge_drive_with_overcurrent_trip_unit_defines.svh @@
// Assertion macros for the H-bridge drive with overcurrent trip.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HBRIDGE_DRIVE_WITH_OVERCURRENT_TRIP_UNIT_DEFINES_SVH
`define HBRIDGE_DRIVE_WITH_OVERCURRENT_TRIP_UNIT_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define HBDOT_ASSERT_IMPLIES(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hbdot: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define HBDOT_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hbdot: next-cycle check failed");

`endif

@@ sv/hbdot_pkg.sv @@
// Shared types, codes and constants for the H-bridge drive with overcurrent trip.
// No dependencies.
`timescale 1ns / 1ps

package hbdot_pkg;

  localparam int LEVEL_W     = 10;
  localparam int PWM_W       = 11;
  localparam int DUTY_W      = 7;
  localparam int REQ_W       = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int PINS_W      = 3;

  localparam logic [REQ_W-1:0] REQ_RUN         = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STOP        = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE      = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_FAULT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR_FAULT = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_FORWARD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_REVERSE = 2'd1;

  localparam logic [LEVEL_W-1:0] LIMIT_FORWARD_RESET = 10'd400;
  localparam logic [LEVEL_W-1:0] LIMIT_REVERSE_RESET = 10'd100;

  // Pin word: bit 0 select, bit 1 bridge input A, bit 2 bridge input B.
  localparam logic [PINS_W-1:0] PINS_FORWARD = 3'b011;
  localparam logic [PINS_W-1:0] PINS_REVERSE = 3'b100;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // duty * 1024 / 100 equals duty * 256 / 25; the reciprocal of 25 scaled by
  // 2^20 and rounded up is exact for every duty up to 100.
  localparam int          PWM_RECIP_W = 16;
  localparam int          PWM_SHIFT   = 12;
  localparam logic [PWM_RECIP_W-1:0] PWM_RECIP = 16'd41944;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic               direction;
    logic [DUTY_W-1:0]  duty_percent;
    logic [LEVEL_W-1:0] current_sample;
  } req_t;

  typedef struct packed {
    logic               drive_select;
    logic               drive_a;
    logic               drive_b;
    logic [PWM_W-1:0]   pwm_level;
    logic               running;
    logic               fault;
    logic [LEVEL_W-1:0] mean_current;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } ram_ctl_t;

  function automatic logic [PWM_W-1:0] pwm_from_duty(input logic [DUTY_W-1:0] duty);
    logic [DUTY_W-1:0]             sat;
    logic [DUTY_W+PWM_RECIP_W-1:0] prod;
    sat  = (duty > DUTY_MAX) ? DUTY_MAX : duty;
    prod = sat * PWM_RECIP;
    return prod[PWM_SHIFT +: PWM_W];
  endfunction

endpackage

@@ sv/hbridge_drive_with_overcurrent_trip_unit.sv @@
// Top level of the H-bridge drive with moving-average overcurrent trip.
// Depends on hbdot_pkg, hbdot_sample_ram and the assertion macro header.
//
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   req      in         req_valid / req_ready  req (req_t)
//   rsp      out        rsp_valid / rsp_ready  rsp (rsp_t)
//
// One item per cycle unless rsp is stalled; a request waits in p1 while the
// sample window memory is read, then updates the state and loads rsp.
// The configuration port always accepts; cfg_ready is tied high.
// Reset is synchronous; the window valid bits clear at once, with no sweep.
// A stalled result register holds the item behind it, and req_ready drops.
`timescale 1ns / 1ps
`include "hbridge_drive_with_overcurrent_trip_unit_defines.svh"

module hbridge_drive_with_overcurrent_trip_unit
  import hbdot_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_data,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp
);

  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int SUM_W       = LEVEL_W + SLOT_W;
  localparam int RECIP_SHIFT = SUM_W + SLOT_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [SUM_W:0] MEAN_RECIP = RECIP_FULL[SUM_W:0];
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [LEVEL_W-1:0] limit_forward;
  logic [LEVEL_W-1:0] limit_reverse;

  logic               p1_valid;
  req_t               p1_item;
  logic               p1_go;
  logic               p1_adv;
  logic               req_fire;
  logic               p1_store;

  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  write_slot_next;
  logic [SLOT_W-1:0]  slot_inc;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SUM_W-1:0]   window_sum;
  logic [SUM_W-1:0]   window_sum_next;
  logic [SUM_W-1:0]   sum_stored;
  logic [2*SUM_W:0]   mean_prod;
  logic [LEVEL_W-1:0] mean_calc;
  logic               started_flag;
  logic               started_flag_next;
  logic               fault_flag;
  logic               fault_flag_next;
  logic [LEVEL_W-1:0] active_limit;
  logic [LEVEL_W-1:0] active_limit_next;
  logic [PINS_W-1:0]  drive_pins;
  logic [PINS_W-1:0]  drive_pins_next;
  logic [PWM_W-1:0]   pwm_value;
  logic [PWM_W-1:0]   pwm_value_next;
  logic [LEVEL_W-1:0] last_mean;
  logic [LEVEL_W-1:0] last_mean_next;
  rsp_t               rsp_next;

  ram_ctl_t           ram_ctl;
  logic [LEVEL_W-1:0] old_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_forward <= LIMIT_FORWARD_RESET;
      limit_reverse <= LIMIT_REVERSE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIMIT_FORWARD: limit_forward <= cfg_data;
        CFG_LIMIT_REVERSE: limit_reverse <= cfg_data;
        default: ;
      endcase
    end
  end

  assign p1_go     = !rsp_valid || rsp_ready;
  assign p1_adv    = p1_valid && p1_go;
  assign req_ready = !p1_valid || p1_go;
  assign req_fire  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (req_ready) begin
      p1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      p1_item <= req;
    end
  end

  // The read for the incoming item addresses the slot left by the item ahead of it.
  assign p1_store        = p1_valid && p1_item.req_type == REQ_SAMPLE && started_flag;
  assign slot_inc        = (write_slot == SLOT_LAST) ? '0 : write_slot + 1'b1;
  assign write_slot_next = (p1_adv && p1_store) ? slot_inc : write_slot;
  assign rd_addr         = write_slot_next;

  assign ram_ctl.rd_en = req_fire;
  assign ram_ctl.wr_en = p1_adv && p1_store;
  assign ram_ctl.clear = p1_adv && p1_item.req_type == REQ_STOP;

  hbdot_sample_ram #(
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ram_ctl),
    .rd_addr (rd_addr),
    .wr_addr (write_slot),
    .wr_data (p1_item.current_sample),
    .rd_data (old_sample)
  );

  assign sum_stored = window_sum - SUM_W'(old_sample) + SUM_W'(p1_item.current_sample);
  assign mean_prod  = sum_stored * MEAN_RECIP;
  assign mean_calc  = mean_prod[RECIP_SHIFT +: LEVEL_W];

  always_comb begin
    window_sum_next   = window_sum;
    started_flag_next = started_flag;
    fault_flag_next   = fault_flag;
    active_limit_next = active_limit;
    drive_pins_next   = drive_pins;
    pwm_value_next    = pwm_value;
    last_mean_next    = last_mean;
    case (p1_item.req_type)
      REQ_RUN: begin
        if (!fault_flag) begin
          drive_pins_next   = p1_item.direction ? PINS_FORWARD : PINS_REVERSE;
          active_limit_next = p1_item.direction ? limit_forward : limit_reverse;
          pwm_value_next    = pwm_from_duty(p1_item.duty_percent);
          started_flag_next = 1'b1;
        end
      end
      REQ_STOP: begin
        pwm_value_next    = '0;
        started_flag_next = 1'b0;
        window_sum_next   = '0;
      end
      REQ_SAMPLE: begin
        if (started_flag) begin
          window_sum_next = sum_stored;
          last_mean_next  = mean_calc;
          fault_flag_next = mean_calc > active_limit;
        end else begin
          fault_flag_next = 1'b0;
        end
      end
      REQ_SET_FAULT:   fault_flag_next = 1'b1;
      REQ_CLEAR_FAULT: fault_flag_next = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    rsp_next.drive_select = drive_pins_next[0];
    rsp_next.drive_a      = drive_pins_next[1];
    rsp_next.drive_b      = drive_pins_next[2];
    rsp_next.pwm_level    = pwm_value_next;
    rsp_next.running      = started_flag_next;
    rsp_next.fault        = fault_flag_next;
    rsp_next.mean_current = last_mean_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      window_sum   <= '0;
      started_flag <= 1'b0;
      fault_flag   <= 1'b0;
      active_limit <= '0;
      drive_pins   <= '0;
      pwm_value    <= '0;
      last_mean    <= '0;
    end else if (p1_adv) begin
      write_slot   <= write_slot_next;
      window_sum   <= window_sum_next;
      started_flag <= started_flag_next;
      fault_flag   <= fault_flag_next;
      active_limit <= active_limit_next;
      drive_pins   <= drive_pins_next;
      pwm_value    <= pwm_value_next;
      last_mean    <= last_mean_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p1_go) begin
      rsp_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      rsp <= rsp_next;
    end
  end

  `HBDOT_ASSERT_IMPLIES(a_read_write_apart, ram_ctl.rd_en && ram_ctl.wr_en, rd_addr != write_slot)
  `HBDOT_ASSERT_NEXT(a_stop_clears, ram_ctl.clear, window_sum == '0 && pwm_value == '0 && !started_flag)
  `HBDOT_ASSERT_NEXT(a_stalled_read_holds, p1_valid && !p1_go, $stable(old_sample))
  `HBDOT_ASSERT_NEXT(a_trip_follows_mean, ram_ctl.wr_en, fault_flag == (last_mean > active_limit))

endmodule

@@ sv/hbdot_sample_ram.sv @@
// Sample window memory: one write and one registered read per cycle.
// Per-entry valid bits make a cleared or unwritten entry read as zero; uses hbdot_pkg.
`timescale 1ns / 1ps

module hbdot_sample_ram
  import hbdot_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  ram_ctl_t           ctl,
  input  logic [ADDR_W-1:0]  rd_addr,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [LEVEL_W-1:0] wr_data,
  output logic [LEVEL_W-1:0] rd_data
);

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [LEVEL_W-1:0] mem_q;
  logic [DEPTH-1:0]   entry_valid;
  logic               hit_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (ctl.clear) begin
        entry_valid <= '0;
      end else if (ctl.wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        hit_q <= entry_valid[rd_addr] & ~ctl.clear;
      end
    end
  end

  assign rd_data = hit_q ? mem_q : '0;

endmodule

@@ bench/hbridge_drive_with_overcurrent_trip_unit_test.sv @@
// Self-checking bench for the H-bridge drive with moving-average overcurrent trip.
// Drives requests and limit writes from a queue and checks each result transfer.
// Depends on hbdot_pkg and hbridge_drive_with_overcurrent_trip_unit.
`timescale 1ns / 1ps

module hbridge_drive_with_overcurrent_trip_unit_test;
  import hbdot_pkg::*;

  localparam int WINDOW_LEN = 8;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int SUM_W      = LEVEL_W + SLOT_W;
  localparam int REQ_BITS   = $bits(req_t);
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CONFIG,
    OP_DRAIN
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    req_t                   item;
    logic [CFG_INDEX_W-1:0] index;
    logic [LEVEL_W-1:0]     data;
  } pending_op_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LEVEL_W-1:0]     cfg_data = '0;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  req_t                   req_item = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_t                   rsp_item;

  pending_op_t pending_ops[$];
  rsp_t        expected_rsp[$];
  int          error_count = 0;
  int          idle_cycles = 0;

  // Shadow of the drive state.
  logic [LEVEL_W-1:0] lim_forward;
  logic [LEVEL_W-1:0] lim_reverse;
  logic [LEVEL_W-1:0] m_window[WINDOW_LEN];
  logic [SLOT_W-1:0]  m_slot;
  logic [SUM_W-1:0]   m_sum;
  logic               m_started;
  logic               m_fault;
  logic [LEVEL_W-1:0] m_limit;
  logic [PINS_W-1:0]  m_pins;
  logic [PWM_W-1:0]   m_pwm;
  logic [LEVEL_W-1:0] m_mean;

  // Sender and receiver pacing.
  int          burst_left = 1;
  int          gap_left = 0;
  logic        offer_req;
  logic        offer_cfg;
  pending_op_t head;
  int          rx_count = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  logic        ready_next;

  hbridge_drive_with_overcurrent_trip_unit #(
    .WINDOW(WINDOW_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp_item)
  );

  always #4 clk = ~clk;

  function automatic void reset_drive_state();
    lim_forward = LIMIT_FORWARD_RESET;
    lim_reverse = LIMIT_REVERSE_RESET;
    m_window    = '{default: '0};
    m_slot      = '0;
    m_sum       = '0;
    m_started   = 1'b0;
    m_fault     = 1'b0;
    m_limit     = '0;
    m_pins      = '0;
    m_pwm       = '0;
    m_mean      = '0;
  endfunction

  function automatic void write_limit(input logic [CFG_INDEX_W-1:0] index,
                                      input logic [LEVEL_W-1:0] data);
    if (index == CFG_LIMIT_FORWARD) begin
      lim_forward = data;
    end else if (index == CFG_LIMIT_REVERSE) begin
      lim_reverse = data;
    end
  endfunction

  function automatic rsp_t predict_drive(input req_t r);
    logic [DUTY_W-1:0] duty;
    rsp_t              o;
    case (r.req_type)
      REQ_RUN: begin
        if (!m_fault) begin
          duty = (r.duty_percent > DUTY_MAX) ? DUTY_MAX : r.duty_percent;
          if (r.direction) begin
            m_pins  = PINS_FORWARD;
            m_limit = lim_forward;
          end else begin
            m_pins  = PINS_REVERSE;
            m_limit = lim_reverse;
          end
          m_pwm     = PWM_W'((32'(duty) * 32'd1024) / 32'd100);
          m_started = 1'b1;
        end
      end
      REQ_STOP: begin
        m_pwm     = '0;
        m_started = 1'b0;
        m_window  = '{default: '0};
        m_sum     = '0;
      end
      REQ_SAMPLE: begin
        if (m_started) begin
          m_sum            = m_sum - SUM_W'(m_window[m_slot]) + SUM_W'(r.current_sample);
          m_window[m_slot] = r.current_sample;
          m_slot           = (m_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : m_slot + 1'b1;
          m_mean           = LEVEL_W'(m_sum / WINDOW_LEN);
          m_fault          = m_mean > m_limit;
        end else begin
          m_fault = 1'b0;
        end
      end
      REQ_SET_FAULT: begin
        m_fault = 1'b1;
      end
      REQ_CLEAR_FAULT: begin
        m_fault = 1'b0;
      end
      default: begin
      end
    endcase
    o.drive_select = m_pins[0];
    o.drive_a      = m_pins[1];
    o.drive_b      = m_pins[2];
    o.pwm_level    = m_pwm;
    o.running      = m_started;
    o.fault        = m_fault;
    o.mean_current = m_mean;
    return o;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 10) begin
      $display("%s", msg);
    end
    error_count++;
  endtask

  function automatic void add_item(input logic [REQ_W-1:0] kind, input logic dir,
                                   input logic [DUTY_W-1:0] duty,
                                   input logic [LEVEL_W-1:0] level);
    pending_op_t op;
    op.kind                = OP_ITEM;
    op.item.req_type       = kind;
    op.item.direction      = dir;
    op.item.duty_percent   = duty;
    op.item.current_sample = level;
    op.index               = '0;
    op.data                = '0;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_config(input logic [CFG_INDEX_W-1:0] index,
                                     input logic [LEVEL_W-1:0] data);
    pending_op_t op;
    op.kind  = OP_CONFIG;
    op.item  = '0;
    op.index = index;
    op.data  = data;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_drain();
    pending_op_t op;
    op       = '0;
    op.kind  = OP_DRAIN;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [LEVEL_W-1:0] near_level(input int center);
    int v;
    v = center + $urandom_range(0, 48) - 24;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return LEVEL_W'(v);
  endfunction

  function automatic void add_random_item(input int fwd, input int rev);
    req_t r;
    int   pick;
    r    = REQ_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.req_type = REQ_RUN;
      if ($urandom_range(0, 9) < 8) begin
        r.duty_percent = DUTY_W'($urandom_range(0, 100));
      end else begin
        r.duty_percent = DUTY_W'($urandom_range(101, 127));
      end
    end else if (pick < 72) begin
      r.req_type = REQ_SAMPLE;
      case ($urandom_range(0, 4))
        0: r.current_sample = near_level(fwd);
        1: r.current_sample = near_level(rev);
        2: r.current_sample = ($urandom_range(0, 1) != 0) ? 10'h3FF : 10'h000;
        3: r.current_sample = LEVEL_W'($urandom_range(0, 150));
        default: begin
        end
      endcase
    end else if (pick < 80) begin
      r.req_type = REQ_STOP;
    end else if (pick < 86) begin
      r.req_type = REQ_SET_FAULT;
    end else if (pick < 95) begin
      r.req_type = REQ_CLEAR_FAULT;
    end else begin
      r.req_type = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    end
    add_item(r.req_type, r.direction, r.duty_percent, r.current_sample);
  endfunction

  // Sender: transfers are recorded at the edge, then the next op is offered.
  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      cfg_valid  <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
      reset_drive_state();
    end else begin
      if (req_valid && req_ready) begin
        expected_rsp.push_back(predict_drive(req_item));
      end
      if (cfg_valid && cfg_ready) begin
        write_limit(cfg_index, cfg_data);
      end
      offer_req = req_valid && !req_ready;
      offer_cfg = cfg_valid && !cfg_ready;
      if (!offer_req && !offer_cfg) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_ops.size() != 0) begin
          head = pending_ops[0];
          case (head.kind)
            OP_ITEM: begin
              pending_ops.delete(0);
              req_item  <= head.item;
              offer_req = 1'b1;
              if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 48);
                gap_left   <= ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
              end else begin
                burst_left <= burst_left - 1;
              end
            end
            OP_CONFIG: begin
              if (expected_rsp.size() == 0) begin
                pending_ops.delete(0);
                cfg_index <= head.index;
                cfg_data  <= head.data;
                offer_cfg = 1'b1;
              end
            end
            default: begin
              if (expected_rsp.size() == 0) begin
                pending_ops.delete(0);
              end
            end
          endcase
        end
      end
      req_valid <= offer_req;
      cfg_valid <= offer_cfg;
    end
  end

  // Receiver: random stall modes, plus long hold-offs after a set number of transfers.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      rx_count   <= 0;
      hold_left  <= 0;
      stall_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rx_count <= rx_count + 1;
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: ready_next = 1'b1;
        1: ready_next = $urandom_range(0, 3) != 0;
        2: ready_next = $urandom_range(0, 1) != 0;
        default: ready_next = $urandom_range(0, 4) == 0;
      endcase
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        ready_next = 1'b0;
      end else if (rsp_valid && rsp_ready && (rx_count == 200 || rx_count == 900)) begin
        hold_left  <= HOLD_CYCLES;
        ready_next = 1'b0;
      end
      rsp_ready <= ready_next;
    end
  end

  // Checker for result transfers.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        flag_error("Result transfer with no expected result pending");
      end else begin
        if (rsp_item.drive_select !== expected_rsp[0].drive_select ||
            rsp_item.drive_a !== expected_rsp[0].drive_a ||
            rsp_item.drive_b !== expected_rsp[0].drive_b ||
            rsp_item.pwm_level !== expected_rsp[0].pwm_level ||
            rsp_item.running !== expected_rsp[0].running ||
            rsp_item.fault !== expected_rsp[0].fault ||
            rsp_item.mean_current !== expected_rsp[0].mean_current) begin
          flag_error($sformatf(
            "Mismatch: exp sel=%b a=%b b=%b pwm=%0d run=%b flt=%b mean=%0d, got sel=%b a=%b b=%b pwm=%0d run=%b flt=%b mean=%0d",
            expected_rsp[0].drive_select, expected_rsp[0].drive_a, expected_rsp[0].drive_b,
            expected_rsp[0].pwm_level, expected_rsp[0].running, expected_rsp[0].fault,
            expected_rsp[0].mean_current, rsp_item.drive_select, rsp_item.drive_a,
            rsp_item.drive_b, rsp_item.pwm_level, rsp_item.running, rsp_item.fault,
            rsp_item.mean_current));
        end
        expected_rsp.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int fwd_set[PHASES];
    int rev_set[PHASES];
    fwd_set = '{400, 0, 1023, 0, 1023, 0, 400, 0};
    rev_set = '{100, 0, 1023, 0, 0, 1023, 100, 0};
    fwd_set[3] = $urandom_range(0, 1023);
    rev_set[3] = $urandom_range(0, 1023);
    fwd_set[7] = $urandom_range(0, 1023);
    rev_set[7] = $urandom_range(0, 1023);

    // Directed part under the reset limits.
    add_item(REQ_SAMPLE, 1'b1, 7'd127, 10'h3FF);
    add_item(REQ_SET_FAULT, 1'b0, 7'd0, 10'h000);
    add_item(REQ_RUN, 1'b1, 7'd50, 10'h155);
    add_item(REQ_CLEAR_FAULT, 1'b1, 7'd127, 10'h3FF);
    add_item(REQ_RUN, 1'b1, 7'd0, 10'h000);
    add_item(REQ_RUN, 1'b1, 7'd127, 10'h3FF);
    add_item(REQ_RUN, 1'b0, 7'd101, 10'h2AA);
    add_item(REQ_RUN, 1'b1, 7'd100, 10'h000);
    for (int i = 0; i < WINDOW_LEN; i++) begin
      add_item(REQ_SAMPLE, 1'b0, 7'd0, 10'h3FF);
    end
    add_item(REQ_RUN, 1'b0, 7'd25, 10'h000);
    add_item(REQ_SAMPLE, 1'b1, 7'd64, 10'h000);
    add_item(REQ_STOP, 1'b1, 7'd127, 10'h3FF);
    add_item(REQ_SAMPLE, 1'b0, 7'd0, 10'h3FF);
    add_item(REQ_UNUSED_FIRST, 1'b1, 7'd127, 10'h3FF);
    add_item(REQ_W'(REQ_UNUSED_FIRST + 3'd1), 1'b0, 7'd1, 10'h001);
    add_item(REQ_UNUSED_LAST, 1'b1, 7'd99, 10'h200);
    add_item(REQ_RUN, 1'b0, 7'd1, 10'h000);
    add_item(REQ_SAMPLE, 1'b1, 7'd0, 10'h000);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        add_config(CFG_LIMIT_FORWARD, LEVEL_W'(fwd_set[p]));
        add_config(CFG_LIMIT_REVERSE, LEVEL_W'(rev_set[p]));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          add_drain();
        end
        add_random_item(fwd_set[p], rev_set[p]);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || req_valid || cfg_valid || expected_rsp.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
